### design/cobs_pkg.sv
// Shared constants and types for the COBS frame encoder.
// No dependencies; the run buffer and the top level refer to this package.
`timescale 1ns / 1ps

package cobs_pkg;

   // Longest run of non-zero bytes held before a forced flush
   localparam int MAX_RUN   = 61;
   localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);
   localparam int RUN_IDX_W = $clog2(MAX_RUN);

   localparam logic [7:0] FRAME_DELIM = 8'h00;
   localparam logic [7:0] CODE_EMPTY  = 8'h01;
   localparam logic [RUN_CNT_W-1:0] RUN_FULL = RUN_CNT_W'(MAX_RUN);

   // Access bundle for the run buffer memory
   typedef struct packed {
      logic                 wr_en;
      logic [RUN_IDX_W-1:0] wr_addr;
      logic [7:0]           wr_data;
      logic                 rd_en;
      logic [RUN_IDX_W-1:0] rd_addr;
   } buf_req_type;

   // Sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CODE  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_DATA  = 6'b001000,
      ST_ONE   = 6'b010000,
      ST_DELIM = 6'b100000
   } state_type;

endpackage

### design/cobs_req_if.sv
// Input channel: one raw payload byte per beat with its end-of-packet flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface cobs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       packet_end;

   modport source (output valid, output data_byte, output packet_end, input ready);
   modport sink   (input valid, input data_byte, input packet_end, output ready);
endinterface

### design/cobs_rsp_if.sv
// Result channel: one encoded byte per beat, flagged on the last of an item.
// Depends on nothing.
`timescale 1ns / 1ps

interface cobs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;

   modport source (output valid, output out_byte, output run_last, input ready);
   modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

### design/cobs_run_buf.sv
// Run buffer: single-port-write, single-read memory of MAX_RUN bytes,
// read data registered. Depends on cobs_pkg.
`timescale 1ns / 1ps

module cobs_run_buf (
   input  logic                 clock,
   input  cobs_pkg::buf_req_type acc,
   output logic [7:0]           rd_data
);

   logic [7:0] mem [cobs_pkg::MAX_RUN];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (acc.wr_en) begin
         mem[acc.wr_addr] <= acc.wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (acc.rd_en) begin
         rd_data_ff <= mem[acc.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/cobs_frame_encoder_unit.sv
// COBS frame encoder top level: sequencer, run count and output register.
// Depends on cobs_pkg, cobs_req_if, cobs_rsp_if and cobs_run_buf.
`timescale 1ns / 1ps

// A non-zero byte that neither fills the run nor ends the packet is stored in
// the run buffer and produces no output. An item that flushes a run of n bytes
// emits the code byte, then the n stored bytes, then for a packet end 0x01
// (only when the run was already flushed) and the 0x00 delimiter. Each stored
// byte is first read from the run buffer memory (ST_READ) and then loaded into
// the output register (ST_DATA); a stalling sink holds the loads. The next item
// is taken once the last output beat of the current one is loaded into the
// output register. The run buffer needs no clearing after reset.
module cobs_frame_encoder_unit (
   input logic      clock,
   input logic      reset,
   cobs_req_if.sink   req_chan,
   cobs_rsp_if.source rsp_chan
);

   localparam int CW = cobs_pkg::RUN_CNT_W;
   localparam int IW = cobs_pkg::RUN_IDX_W;

   cobs_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;    // bytes held in the run buffer
   logic [CW-1:0] len_ff, len_in;        // bytes in the run being flushed
   logic [IW-1:0] idx_ff, idx_in;        // read pointer during a flush
   logic          tail_one_ff, tail_one_in;
   logic          tail_zero_ff, tail_zero_in;

   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_last_ff, out_last_in;

   cobs_pkg::buf_req_type acc;
   logic [7:0]    rd_data;

   logic          accept;
   logic          slot_free;
   logic          is_zero;
   logic [CW-1:0] new_cnt;
   logic          flush_now;
   logic          idx_at_end;

   cobs_run_buf u_buf (
      .clock   (clock),
      .acc     (acc),
      .rd_data (rd_data)
   );

   assign req_chan.ready    = (state_ff == cobs_pkg::ST_IDLE);
   assign accept            = req_chan.valid && req_chan.ready;
   assign slot_free         = !out_valid_ff || rsp_chan.ready;

   assign is_zero    = (req_chan.data_byte == 8'h00);
   assign new_cnt    = is_zero ? count_ff : count_ff + CW'(1);
   assign flush_now  = is_zero || (new_cnt == cobs_pkg::RUN_FULL);
   assign idx_at_end = (idx_ff == IW'(len_ff - CW'(1)));

   // Sequencer and output register loading
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      tail_one_in  = tail_one_ff;
      tail_zero_in = tail_zero_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      acc          = '0;

      unique case (state_ff)
         cobs_pkg::ST_IDLE: begin
            if (accept) begin
               acc.wr_en    = !is_zero;
               acc.wr_addr  = count_ff[IW-1:0];
               acc.wr_data  = req_chan.data_byte;
               len_in       = new_cnt;
               idx_in       = '0;
               tail_one_in  = req_chan.packet_end && flush_now;
               tail_zero_in = req_chan.packet_end;
               if (flush_now || req_chan.packet_end) begin
                  count_in = '0;
                  state_in = cobs_pkg::ST_CODE;
               end else begin
                  count_in = new_cnt;
               end
            end
         end
         cobs_pkg::ST_CODE: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_byte_in  = {{(8-CW){1'b0}}, len_ff} + 8'd1;
               out_last_in  = (len_ff == '0) && !tail_zero_ff;
               if (len_ff != '0) begin
                  state_in = cobs_pkg::ST_READ;
               end else if (tail_one_ff) begin
                  state_in = cobs_pkg::ST_ONE;
               end else if (tail_zero_ff) begin
                  state_in = cobs_pkg::ST_DELIM;
               end else begin
                  state_in = cobs_pkg::ST_IDLE;
               end
            end
         end
         cobs_pkg::ST_READ: begin
            acc.rd_en   = 1'b1;
            acc.rd_addr = idx_ff;
            state_in    = cobs_pkg::ST_DATA;
         end
         cobs_pkg::ST_DATA: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_byte_in  = rd_data;
               out_last_in  = idx_at_end && !tail_zero_ff;
               idx_in       = idx_ff + IW'(1);
               if (!idx_at_end) begin
                  state_in = cobs_pkg::ST_READ;
               end else if (tail_one_ff) begin
                  state_in = cobs_pkg::ST_ONE;
               end else if (tail_zero_ff) begin
                  state_in = cobs_pkg::ST_DELIM;
               end else begin
                  state_in = cobs_pkg::ST_IDLE;
               end
            end
         end
         cobs_pkg::ST_ONE: begin
            // run was flushed just before the packet end: empty final block
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_byte_in  = cobs_pkg::CODE_EMPTY;
               out_last_in  = 1'b0;
               state_in     = cobs_pkg::ST_DELIM;
            end
         end
         cobs_pkg::ST_DELIM: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_byte_in  = cobs_pkg::FRAME_DELIM;
               out_last_in  = 1'b1;
               state_in     = cobs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cobs_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cobs_pkg::ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      idx_ff       <= idx_in;
      tail_one_ff  <= tail_one_in;
      tail_zero_ff <= tail_zero_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.out_byte = out_byte_ff;
   assign rsp_chan.run_last = out_last_ff;

endmodule

### tb/sv/cobs_encoding_tracker_pkg.sv
// Scoreboard for the COBS frame encoder: predicts the encoded byte stream
// and checks each result beat. Depends on cobs_pkg.
`timescale 1ns / 1ps

package cobs_encoding_tracker_pkg;

   import cobs_pkg::*;

   // One expected beat on the result channel
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } encoded_beat_t;

   class cobs_encoding_tracker;

      localparam int REPORT_LIMIT = 10;

      // Copy of the encoder state
      logic [7:0]    run_bytes [MAX_RUN];
      int            run_len;
      encoded_beat_t expected_beats [$];
      int            mismatch_count;

      function new();
         run_len        = 0;
         mismatch_count = 0;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      function void push_beat(logic [7:0] value);
         encoded_beat_t beat;
         beat.out_byte = value;
         beat.run_last = 1'b0;
         expected_beats.push_back(beat);
      endfunction

      // Code byte (run length + 1), the held bytes, then an empty run
      function void flush_run();
         push_beat(8'(run_len + 1));
         for (int i = 0; i < run_len; i++)
            push_beat(run_bytes[i]);
         run_len = 0;
      endfunction

      // Accepted payload beat: work out every encoded byte it causes
      function void note_payload_byte(logic [7:0] data, logic pkt_end);
         int            first_idx;
         encoded_beat_t tail;
         first_idx = expected_beats.size();
         if (data == 8'h00) begin
            flush_run();
         end else begin
            if (run_len < MAX_RUN) begin
               run_bytes[run_len] = data;
               run_len++;
            end
            // full run goes out at once, no implied zero
            if (run_len >= MAX_RUN)
               flush_run();
         end
         if (pkt_end) begin
            flush_run();
            push_beat(FRAME_DELIM);
         end
         // mark the final beat of this item
         if (expected_beats.size() > first_idx) begin
            tail = expected_beats.pop_back();
            tail.run_last = 1'b1;
            expected_beats.push_back(tail);
         end
      endfunction

      function void flag_mismatch(string msg);
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] MISMATCH: %s", $time, msg);
      endfunction

      // Accepted result beat against the oldest expectation
      function void check_encoded_byte(logic [7:0] got_byte, logic got_last);
         encoded_beat_t want;
         if (expected_beats.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat out_byte=%02h run_last=%b",
                                    got_byte, got_last));
         end else begin
            want = expected_beats.pop_front();
            if (got_byte !== want.out_byte || got_last !== want.run_last)
               flag_mismatch($sformatf("expected out_byte=%02h run_last=%b, got %02h %b",
                                       want.out_byte, want.run_last, got_byte, got_last));
         end
      endfunction

      // End of run: anything still waiting is a failure
      function void close_out();
         if (expected_beats.size() != 0)
            flag_mismatch($sformatf("%0d expected beats never arrived",
                                    expected_beats.size()));
      endfunction

   endclass

endpackage

### tb/sv/cobs_frame_encoder_unit_tb.sv
// Top-level testbench for cobs_frame_encoder_unit: directed and random packets,
// bursty sender, stalling receiver. Depends on cobs_pkg, the two channel
// interfaces and cobs_encoding_tracker_pkg.
`timescale 1ns / 1ps

module cobs_frame_encoder_unit_tb;

   import cobs_pkg::*;
   import cobs_encoding_tracker_pkg::*;

   localparam int RANDOM_ITEMS = 112;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 500000;

   typedef enum int {PK_SHORT, PK_MEDIUM, PK_FULL_END, PK_OVERRUN} packet_kind_e;
   typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_EVERY_THIRD} stall_mode_e;

   logic clock;
   logic reset;

   cobs_req_if req ();
   cobs_rsp_if rsp ();

   cobs_frame_encoder_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   cobs_encoding_tracker tracker;

   int burst_left    = 0;
   int payload_beats = 0;
   int cycle_count   = 0;
   bit hold_request  = 1'b0;

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Beat monitor: both channels sampled at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready)
            tracker.note_payload_byte(req.data_byte, req.packet_end);
         if (rsp.valid && rsp.ready)
            tracker.check_encoded_byte(rsp.out_byte, rsp.run_last);
      end
   end

   // Receiver: phases of differing stall patterns, plus one long hold-off
   initial begin
      int          phase_left;
      int          hold_left;
      stall_mode_e mode;
      phase_left = 0;
      hold_left  = 0;
      mode       = RX_ALWAYS;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               mode       = stall_mode_e'($urandom_range(0, 3));
               phase_left = $urandom_range(8, 60);
            end
            phase_left--;
            case (mode)
               RX_ALWAYS:      rsp.ready <= 1'b1;
               RX_MOSTLY:      rsp.ready <= ($urandom_range(0, 3) != 0);
               RX_RARELY:      rsp.ready <= ($urandom_range(0, 3) == 0);
               default:        rsp.ready <= (phase_left % 3 == 0);
            endcase
         end
      end
   end

   // One payload beat, sent in bursts with random gaps between them
   task automatic send_beat(input logic [7:0] data, input logic pkt_end);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 10);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req.valid      <= 1'b1;
      req.data_byte  <= data;
      req.packet_end <= pkt_end;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      payload_beats++;
   endtask

   // Stop offering and let every predicted byte come out
   task automatic wait_for_drain();
      req.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // Stimulus
   initial begin
      packet_kind_e kind;
      int           len;
      int           packet_idx;
      int           random_start;
      logic [7:0]   value;

      tracker = new();
      reset          <= 1'b1;
      req.valid      <= 1'b0;
      req.data_byte  <= 8'h00;
      req.packet_end <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: lone zero, lone 0xFF, zero ending a packet, runs around zeros
      send_beat(8'h00, 1'b1);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h01, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h80, 1'b0);
      send_beat(8'h7F, 1'b1);
      send_beat(8'h00, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'hAA, 1'b0);
      send_beat(8'h00, 1'b1);
      send_beat(8'h55, 1'b0);
      send_beat(8'hA5, 1'b0);
      send_beat(8'h5A, 1'b1);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h01, 1'b1);
      send_beat(8'hFE, 1'b0);
      send_beat(8'h00, 1'b1);

      // Sender pauses until every directed result is out
      wait_for_drain();

      // Random packets; the first one ends exactly on a full run
      random_start = payload_beats;
      packet_idx   = 0;
      while (payload_beats - random_start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0:          kind = PK_OVERRUN;
            1:          kind = PK_FULL_END;
            2, 3, 4, 5: kind = PK_MEDIUM;
            default:    kind = PK_SHORT;
         endcase
         if (packet_idx == 0)
            kind = PK_FULL_END;
         if (packet_idx == 1)
            hold_request = 1'b1;

         case (kind)
            PK_SHORT:    len = $urandom_range(1, 8);
            PK_MEDIUM:   len = $urandom_range(9, 30);
            PK_FULL_END: len = MAX_RUN;
            default:     len = $urandom_range(MAX_RUN + 1, MAX_RUN + 9);
         endcase
         // keep the total close to the item budget
         if (len > RANDOM_ITEMS - (payload_beats - random_start))
            len = RANDOM_ITEMS - (payload_beats - random_start);

         for (int i = 0; i < len; i++) begin
            case (kind)
               PK_SHORT:  value = ($urandom_range(0, 3) == 0) ? 8'h00
                                                              : 8'($urandom_range(1, 255));
               PK_MEDIUM: value = ($urandom_range(0, 11) == 0) ? 8'h00
                                                               : 8'($urandom_range(1, 255));
               default:   value = 8'($urandom_range(1, 255));
            endcase
            send_beat(value, i == len - 1);
         end
         packet_idx++;
      end

      // Wind down: all results in, then a short settle
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      tracker.close_out();
      if (tracker.mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
